// ----- rtl/tlbpt_pkg.sv -----
// Shared types, codes and default sizes for the TLB / page-table address translator.
// No dependencies; imported by tlbpt_pt_mem and tlb_page_table_address_translator.
`timescale 1ns / 1ps
`default_nettype none

package tlbpt_pkg;

    localparam int PAGE_BYTES_DEF  = 128;
    localparam int TLB_ENTRIES_DEF = 4;
    localparam int PT_ENTRIES_DEF  = 256;

    localparam int OP_W     = 2;
    localparam int VADDR_W  = 32;
    localparam int SIZE_W   = 2;
    localparam int IDX_W    = 8;
    localparam int EVPN_W   = 25;
    localparam int PPN_W    = 16;
    localparam int FAULT_W  = 3;
    localparam int PA_W     = 23;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W    = 17;
    localparam int PTS_W    = 9;
    localparam int NPP_W    = 17;

    typedef enum logic [OP_W-1:0] {
        OP_READ     = 2'd0,
        OP_WRITE    = 2'd1,
        OP_LOAD_TLB = 2'd2,
        OP_LOAD_PT  = 2'd3
    } op_t;

    localparam logic [SIZE_W-1:0] SZ_BYTE = 2'd0;
    localparam logic [SIZE_W-1:0] SZ_HALF = 2'd1;
    localparam logic [SIZE_W-1:0] SZ_WORD = 2'd2;

    localparam logic [FAULT_W-1:0] FLT_NONE = 3'd0;
    localparam logic [FAULT_W-1:0] FLT_ADDR = 3'd1;
    localparam logic [FAULT_W-1:0] FLT_MISS = 3'd2;
    localparam logic [FAULT_W-1:0] FLT_RO   = 3'd3;
    localparam logic [FAULT_W-1:0] FLT_BUS  = 3'd4;
    localparam logic [FAULT_W-1:0] FLT_PAGE = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_USE_TLB = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PT_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NPHYS   = 2'd2;

    localparam logic [PTS_W-1:0] PT_SIZE_RST = 9'd256;
    localparam logic [NPP_W-1:0] NPHYS_RST   = 17'd128;

    typedef struct packed {
        logic             valid;
        logic             ro;
        logic [PPN_W-1:0] ppn;
    } pte_t;

    typedef struct packed {
        logic              valid;
        logic              ro;
        logic [EVPN_W-1:0] vpn;
        logic [PPN_W-1:0]  ppn;
    } tlb_ent_t;

endpackage

`default_nettype wire

// ----- rtl/tlbpt_pt_mem.sv -----
// Single-port page-table memory with registered read and a clearing pass after reset.
// Depends on tlbpt_pkg (pte_t).
`timescale 1ns / 1ps
`default_nettype none

module tlbpt_pt_mem #(
    parameter int PT_ENTRIES = tlbpt_pkg::PT_ENTRIES_DEF,
    parameter int AW         = (PT_ENTRIES > 1) ? $clog2(PT_ENTRIES) : 1
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            rd_en,
    input  wire logic            wr_en,
    input  wire logic [AW-1:0]   addr,
    input  wire tlbpt_pkg::pte_t wdata,
    output tlbpt_pkg::pte_t      rdata,
    output logic                 busy
);
    import tlbpt_pkg::*;

    pte_t          mem [PT_ENTRIES];
    pte_t          rdata_reg;
    logic          clr_busy_reg;
    logic [AW-1:0] clr_addr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clr_busy_reg) begin
            clr_addr_reg <= clr_addr_reg + AW'(1);
            if (clr_addr_reg == AW'(PT_ENTRIES - 1)) begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            mem[clr_addr_reg] <= '0;
        end else if (wr_en) begin
            mem[addr] <= wdata;
        end
        if (rd_en) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;
    assign busy  = clr_busy_reg;

endmodule

`default_nettype wire

// ----- rtl/tlb_page_table_address_translator.sv -----
// Top level: virtual-to-physical translator through a small TLB or a linear page table.
// Depends on tlbpt_pkg and tlbpt_pt_mem.
//
// Usage:
//   s_* channel carries one operation per beat: translate read/write, or load a
//   TLB slot / page-table entry. m_* channel returns one beat per input beat:
//   fault code and physical address (zero on faults and loads).
//   cfg_* is a plain write port for use_tlb, page_table_size and num_phys_pages;
//   write it only while no beat is in flight.
// Pipeline: an accepted beat is registered into the input stage together with the
//   page-table read; the fault/address logic is then registered into the output
//   register, which drives m_valid.
// Throughput: one beat per cycle when not stalled or clearing, set by the single-port
//   page-table memory that takes at most one read or one write per accepted beat.
// Reset: configuration and valid registers return to defaults, TLB slots invalid;
//   the page table is then cleared entry by entry, during which s_ready stays low.
// Stall: a held output keeps its beat; the input stage fills behind it and
//   s_ready drops when both stages are occupied or while the page table is cleared.
`timescale 1ns / 1ps
`default_nettype none

module tlb_page_table_address_translator #(
    parameter int PAGE_BYTES  = tlbpt_pkg::PAGE_BYTES_DEF,
    parameter int TLB_ENTRIES = tlbpt_pkg::TLB_ENTRIES_DEF,
    parameter int PT_ENTRIES  = tlbpt_pkg::PT_ENTRIES_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,

    input  wire logic                             cfg_we,
    input  wire logic [tlbpt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tlbpt_pkg::CFG_W-1:0]      cfg_wdata,

    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [tlbpt_pkg::OP_W-1:0]       s_operation,
    input  wire logic [tlbpt_pkg::VADDR_W-1:0]    s_vaddr,
    input  wire logic [tlbpt_pkg::SIZE_W-1:0]     s_access_size,
    input  wire logic [tlbpt_pkg::IDX_W-1:0]      s_entry_index,
    input  wire logic [tlbpt_pkg::EVPN_W-1:0]     s_entry_vpn,
    input  wire logic [tlbpt_pkg::PPN_W-1:0]      s_entry_ppn,
    input  wire logic                             s_entry_valid,
    input  wire logic                             s_entry_read_only,

    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [tlbpt_pkg::FAULT_W-1:0]         m_fault,
    output logic [tlbpt_pkg::PA_W-1:0]            m_phys_addr
);
    import tlbpt_pkg::*;

    localparam int OFF_W  = $clog2(PAGE_BYTES);
    localparam int VPN_W  = VADDR_W - OFF_W;
    localparam int TLB_AW = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
    localparam int PT_AW  = (PT_ENTRIES > 1) ? $clog2(PT_ENTRIES) : 1;

    // configuration
    logic             use_tlb_reg;
    logic [PTS_W-1:0] pt_size_reg;
    logic [NPP_W-1:0] nphys_reg;

    // TLB slots
    tlb_ent_t tlb_reg [TLB_ENTRIES];

    // input stage
    logic               st1_valid_reg;
    op_t                st1_op_reg;
    logic [VADDR_W-1:0] st1_vaddr_reg;
    logic [SIZE_W-1:0]  st1_size_reg;

    // output stage
    logic               m_valid_reg;
    logic [FAULT_W-1:0] m_fault_reg;
    logic [PA_W-1:0]    m_phys_addr_reg;

    logic accept;
    logic st1_adv;
    op_t  s_op;
    logic s_xlat;

    logic             pt_rd_en;
    logic             pt_wr_en;
    logic [PT_AW-1:0] pt_addr;
    pte_t             pt_wdata;
    pte_t             pt_rdata;
    logic             pt_busy;

    logic [VPN_W-1:0]   st1_vpn;
    logic               is_xlat;
    logic               misaligned;
    logic               tlb_hit;
    logic [PPN_W-1:0]   tlb_ppn;
    logic               tlb_ro;
    logic [PPN_W-1:0]   frame;
    logic               frame_ro;
    logic               pt_out_of_range;
    logic [FAULT_W-1:0] fault_next;
    logic [PA_W-1:0]    phys_addr_next;

    assign s_op    = op_t'(s_operation);
    assign s_xlat  = (s_op == OP_READ) || (s_op == OP_WRITE);
    assign st1_adv = !m_valid_reg || m_ready;
    assign s_ready = !pt_busy && (!st1_valid_reg || st1_adv);
    assign accept  = s_valid && s_ready;

    always_comb begin
        pt_rd_en = accept && s_xlat;
        pt_wr_en = accept && (s_op == OP_LOAD_PT)
                   && (32'(s_entry_index) < 32'(PT_ENTRIES));
        pt_addr  = pt_wr_en ? PT_AW'(s_entry_index) : PT_AW'(s_vaddr[VADDR_W-1:OFF_W]);
        pt_wdata = '{valid: s_entry_valid, ro: s_entry_read_only, ppn: s_entry_ppn};
    end

    tlbpt_pt_mem #(
        .PT_ENTRIES (PT_ENTRIES),
        .AW         (PT_AW)
    ) u_pt_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (pt_rd_en),
        .wr_en   (pt_wr_en),
        .addr    (pt_addr),
        .wdata   (pt_wdata),
        .rdata   (pt_rdata),
        .busy    (pt_busy)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            use_tlb_reg <= 1'b0;
            pt_size_reg <= PT_SIZE_RST;
            nphys_reg   <= NPHYS_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_USE_TLB: use_tlb_reg <= cfg_wdata[0];
                CFG_PT_SIZE: pt_size_reg <= cfg_wdata[PTS_W-1:0];
                CFG_NPHYS:   nphys_reg   <= cfg_wdata[NPP_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TLB_ENTRIES; i++) begin
                tlb_reg[i] <= '0;
            end
        end else if (accept && (s_op == OP_LOAD_TLB)
                     && (32'(s_entry_index) < 32'(TLB_ENTRIES))) begin
            tlb_reg[s_entry_index[TLB_AW-1:0]] <= '{valid: s_entry_valid,
                                                     ro:    s_entry_read_only,
                                                     vpn:   s_entry_vpn,
                                                     ppn:   s_entry_ppn};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
        end else if (accept) begin
            st1_valid_reg <= 1'b1;
        end else if (st1_adv) begin
            st1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            st1_op_reg    <= s_op;
            st1_vaddr_reg <= s_vaddr;
            st1_size_reg  <= s_access_size;
        end
    end

    // translation checks, in priority order
    assign st1_vpn = st1_vaddr_reg[VADDR_W-1:OFF_W];

    always_comb begin
        tlb_hit = 1'b0;
        tlb_ppn = '0;
        tlb_ro  = 1'b0;
        for (int i = 0; i < TLB_ENTRIES; i++) begin
            if (!tlb_hit && tlb_reg[i].valid && (32'(tlb_reg[i].vpn) == 32'(st1_vpn))) begin
                tlb_hit = 1'b1;
                tlb_ppn = tlb_reg[i].ppn;
                tlb_ro  = tlb_reg[i].ro;
            end
        end
    end

    always_comb begin
        is_xlat    = (st1_op_reg == OP_READ) || (st1_op_reg == OP_WRITE);
        misaligned = ((st1_size_reg == SZ_WORD) && (st1_vaddr_reg[1:0] != 2'b00))
                     || ((st1_size_reg == SZ_HALF) && st1_vaddr_reg[0]);
        pt_out_of_range = (32'(st1_vpn) >= 32'(pt_size_reg))
                          || (32'(st1_vpn) >= 32'(PT_ENTRIES));
        frame    = use_tlb_reg ? tlb_ppn : pt_rdata.ppn;
        frame_ro = use_tlb_reg ? tlb_ro : pt_rdata.ro;

        priority if (!is_xlat) begin
            fault_next = FLT_NONE;
        end else if (misaligned) begin
            fault_next = FLT_ADDR;
        end else if (use_tlb_reg && !tlb_hit) begin
            fault_next = FLT_MISS;
        end else if (!use_tlb_reg && pt_out_of_range) begin
            fault_next = FLT_ADDR;
        end else if (!use_tlb_reg && !pt_rdata.valid) begin
            fault_next = FLT_PAGE;
        end else if (frame_ro && (st1_op_reg == OP_WRITE)) begin
            fault_next = FLT_RO;
        end else if (32'(frame) >= 32'(nphys_reg)) begin
            fault_next = FLT_BUS;
        end else begin
            fault_next = FLT_NONE;
        end

        if (is_xlat && (fault_next == FLT_NONE)) begin
            phys_addr_next = PA_W'({frame, st1_vaddr_reg[OFF_W-1:0]});
        end else begin
            phys_addr_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (st1_adv) begin
            m_valid_reg <= st1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (st1_adv && st1_valid_reg) begin
            m_fault_reg     <= fault_next;
            m_phys_addr_reg <= phys_addr_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_fault     = m_fault_reg;
    assign m_phys_addr = m_phys_addr_reg;

    a_no_accept_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        pt_busy |-> !s_ready)
        else $error("input accepted during page-table clear");

    a_fault_zero_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_fault_reg != FLT_NONE)) |-> (m_phys_addr_reg == '0))
        else $error("nonzero address on faulted beat");

    a_accept_fills_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> st1_valid_reg)
        else $error("accepted beat lost from input stage");

    a_stage_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (st1_valid_reg && !st1_adv) |=> (st1_valid_reg && $stable(st1_vaddr_reg)))
        else $error("input stage changed while output stalled");

endmodule

`default_nettype wire
